// ----- rtl/bls_pkg.sv -----
// Shared types, constants and helpers for the block-linear swizzle address generator.
package bls_pkg;

  localparam int COORD_W    = 14;
  localparam int OFS_W      = 34;
  localparam int BPP_W      = 5;
  localparam int WB_W       = 15;
  localparam int WBB_W      = 20;
  localparam int HBR_W      = 16;
  localparam int XB_W       = 19;
  localparam int PITCH_W    = 21;
  localparam int GSTRIDE_W  = 29;
  localparam int AREA_W     = 37;
  localparam int SURF_W     = 38;
  localparam int POS_W      = 38;
  localparam int LIN_W      = 35;
  localparam int CFG_DATA_W = 17;
  localparam int CFG_IDX_W  = 3;
  localparam int GOB_MAX_LOG2 = 5;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WIDTH_PX,
    CFG_HEIGHT_PX,
    CFG_BLOCK_WIDTH,
    CFG_BLOCK_HEIGHT_PX,
    CFG_BYTES_PER_ELEMENT,
    CFG_TILE_MODE,
    CFG_GOB_HEIGHT_LOG2,
    CFG_ALIGNMENT
  } cfg_reg_t;

  typedef enum logic [2:0] {
    GEO_LOAD,
    GEO_DIV,
    GEO_SCALE,
    GEO_PITCH,
    GEO_AREA,
    GEO_SURF,
    GEO_READY
  } geo_state_t;

  typedef struct packed {
    logic [COORD_W-1:0] block_x;
    logic [COORD_W-1:0] block_y;
  } in_t;

  typedef struct packed {
    logic [OFS_W-1:0] linear_offset;
    logic [OFS_W-1:0] tiled_offset;
    logic             fits_surface;
  } out_t;

  typedef struct packed {
    logic [14:0]      width_px;
    logic [14:0]      height_px;
    logic [4:0]       block_width;
    logic [4:0]       block_height_px;
    logic [BPP_W-1:0] bytes_per_element;
    logic             tile_mode;
    logic [2:0]       gob_height_log2;
    logic [16:0]      alignment;
  } cfg_t;

  typedef struct packed {
    logic                 ready;
    logic [WB_W-1:0]      wb;
    logic [PITCH_W-1:0]   pitch;
    logic [GSTRIDE_W-1:0] gstride;
    logic [SURF_W-1:0]    surf;
  } geo_t;

  function automatic logic [2:0] gob_log2_sat(input logic [2:0] g);
    return (g > 3'(GOB_MAX_LOG2)) ? 3'(GOB_MAX_LOG2) : g;
  endfunction

endpackage

// ----- rtl/bls_geom.sv -----
// Surface geometry sequencer: block counts, pitch, GOB stride and surface size.
module bls_geom (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          restart,
  input  bls_pkg::cfg_t cfg,
  output bls_pkg::geo_t geo
);
  import bls_pkg::*;

  geo_state_t state_r, state_nxt;
  logic [3:0] cnt_r, cnt_nxt;

  logic [15:0]          wnum_r, hnum_r;
  logic [4:0]           wrem_r, hrem_r;
  logic [WBB_W-1:0]     wbb_r;
  logic [HBR_W-1:0]     hbr_r;
  logic [PITCH_W-1:0]   pitch_r;
  logic [GSTRIDE_W-1:0] gstride_r;
  logic [AREA_W-1:0]    area_r;
  logic [SURF_W-1:0]    surf_r;

  logic [4:0]   bw_eff, bh_eff;
  logic [2:0]   g_eff;
  logic [16:0]  amask;
  logic [5:0]   wcand, hcand;
  logic         wge, hge;
  logic [HBR_W-1:0]   hb16, hmask;
  logic [PITCH_W-1:0] wbb21, pmask;
  logic [SURF_W-1:0]  area38;

  assign bw_eff = (cfg.block_width == 5'd0) ? 5'd1 : cfg.block_width;
  assign bh_eff = (cfg.block_height_px == 5'd0) ? 5'd1 : cfg.block_height_px;
  assign g_eff  = gob_log2_sat(cfg.gob_height_log2);
  assign amask  = (cfg.alignment == 17'd0) ? 17'd0 : cfg.alignment - 17'd1;

  // one restoring-division bit per cycle for both dimensions
  assign wcand = {wrem_r, wnum_r[15]};
  assign hcand = {hrem_r, hnum_r[15]};
  assign wge   = wcand >= {1'b0, bw_eff};
  assign hge   = hcand >= {1'b0, bh_eff};

  assign hb16  = {1'b0, hnum_r[WB_W-1:0]};
  assign hmask = HBR_W'((16'd8 << g_eff) - 16'd1);
  assign wbb21 = {1'b0, wbb_r};
  assign pmask = cfg.tile_mode ? PITCH_W'(63) : PITCH_W'(31);
  assign area38 = {1'b0, area_r};

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      GEO_LOAD: begin
        state_nxt = GEO_DIV;
        cnt_nxt   = 4'd15;
      end
      GEO_DIV: begin
        cnt_nxt = cnt_r - 4'd1;
        if (cnt_r == 4'd0) begin
          state_nxt = GEO_SCALE;
        end
      end
      GEO_SCALE: state_nxt = GEO_PITCH;
      GEO_PITCH: state_nxt = GEO_AREA;
      GEO_AREA:  state_nxt = GEO_SURF;
      GEO_SURF:  state_nxt = GEO_READY;
      GEO_READY: state_nxt = GEO_READY;
      default:   state_nxt = GEO_LOAD;
    endcase
    if (restart) begin
      state_nxt = GEO_LOAD;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= GEO_LOAD;
      cnt_r   <= 4'd0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      GEO_LOAD: begin
        wnum_r <= 16'(cfg.width_px) + 16'(bw_eff) - 16'd1;
        hnum_r <= 16'(cfg.height_px) + 16'(bh_eff) - 16'd1;
        wrem_r <= 5'd0;
        hrem_r <= 5'd0;
      end
      GEO_DIV: begin
        wrem_r <= wge ? 5'(wcand - {1'b0, bw_eff}) : wcand[4:0];
        hrem_r <= hge ? 5'(hcand - {1'b0, bh_eff}) : hcand[4:0];
        wnum_r <= {wnum_r[14:0], wge};
        hnum_r <= {hnum_r[14:0], hge};
      end
      GEO_SCALE: begin
        wbb_r <= WBB_W'(wnum_r[WB_W-1:0]) * WBB_W'(cfg.bytes_per_element);
        if (cfg.tile_mode && hb16 != '0) begin
          hbr_r <= ((hb16 - HBR_W'(1)) | hmask) + HBR_W'(1);
        end else begin
          hbr_r <= hb16;
        end
      end
      GEO_PITCH: begin
        pitch_r   <= (wbb21 == '0) ? '0 : ((wbb21 - PITCH_W'(1)) | pmask) + PITCH_W'(1);
        gstride_r <= GSTRIDE_W'((wbb21 + PITCH_W'(63)) >> 6) << (4'd9 + 4'(g_eff));
      end
      GEO_AREA: begin
        area_r <= AREA_W'(pitch_r) * AREA_W'(hbr_r);
      end
      GEO_SURF: begin
        surf_r <= (area38 == '0) ? '0
                  : ((area38 - SURF_W'(1)) | SURF_W'(amask)) + SURF_W'(1);
      end
      GEO_READY: ;
      default: ;
    endcase
  end

  assign geo.ready   = (state_r == GEO_READY);
  assign geo.wb      = wnum_r[WB_W-1:0];
  assign geo.pitch   = pitch_r;
  assign geo.gstride = gstride_r;
  assign geo.surf    = surf_r;

endmodule

// ----- rtl/bls_addr.sv -----
// Four-stage address pipeline: products, offset assembly and surface-fit check.
module bls_addr #(
  parameter int MAX_DIM_BITS = 14
) (
  input  logic          clk,
  input  logic          rst_n,
  input  bls_pkg::cfg_t cfg,
  input  bls_pkg::geo_t geo,
  input  logic          in_valid,
  output logic          in_stall,
  input  bls_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output bls_pkg::out_t out_data
);
  import bls_pkg::*;

  localparam int MaskBits = (MAX_DIM_BITS < COORD_W) ? MAX_DIM_BITS : COORD_W;
  localparam logic [COORD_W-1:0] DIM_MASK = COORD_W'((64'd1 << MaskBits) - 64'd1);

  logic v1_r, v2_r, v3_r, v4_r;
  logic rdy1, rdy2, rdy3, rdy4;
  logic take;

  logic [COORD_W-1:0] x1_r, y1_r;
  logic [COORD_W-1:0] x2_r, y2_r;
  logic [29:0]        ywb2_r;
  logic [34:0]        ypitch2_r;
  logic [XB_W-1:0]    xb2_r;
  logic [POS_W-1:0]   ygob2_r;
  logic [LIN_W-1:0]   lin3_r;
  logic [POS_W-1:0]   pos3_r;
  out_t               out_r;

  logic [2:0]         g_eff;
  logic [3:0]         yshift;
  logic [COORD_W-1:0] ysup;
  logic [42:0]        ygob_prod;
  logic [29:0]        lsum;
  logic [10:0]        gmask;
  logic [POS_W-1:0]   intra, pos_blk, pos_pitch;

  assign g_eff  = gob_log2_sat(cfg.gob_height_log2);
  assign yshift = 4'(g_eff) + 4'd3;

  // each stage moves on when it is empty or the next one takes its request
  assign rdy4 = !v4_r || !out_stall;
  assign rdy3 = !v3_r || rdy4;
  assign rdy2 = !v2_r || rdy3;
  assign rdy1 = !v1_r || rdy2;
  assign in_stall = !(rdy1 && geo.ready);
  assign take = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= take;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
    end
  end

  // stage 2: the coordinate products (the linear-offset product follows in stage 3)
  assign ysup      = y1_r >> yshift;
  assign ygob_prod = 43'(ysup) * 43'(geo.gstride);

  // stage 3: assemble offsets
  assign lsum  = ywb2_r + 30'(x2_r);
  assign gmask = 11'((12'd1 << g_eff) - 12'd1);
  assign intra = POS_W'({xb2_r[5], y2_r[2:1], xb2_r[4], y2_r[0], xb2_r[3:0]});
  assign pos_blk = ygob2_r
                 + (POS_W'(xb2_r[XB_W-1:6]) << (4'd9 + 4'(g_eff)))
                 + (POS_W'(y2_r[COORD_W-1:3] & gmask) << 9)
                 + intra;
  assign pos_pitch = POS_W'(ypitch2_r) + POS_W'(xb2_r);

  always_ff @(posedge clk) begin
    if (rdy1 && take) begin
      x1_r <= in_data.block_x & DIM_MASK;
      y1_r <= in_data.block_y & DIM_MASK;
    end
    if (rdy2 && v1_r) begin
      x2_r      <= x1_r;
      y2_r      <= y1_r;
      ywb2_r    <= 30'(y1_r) * 30'(geo.wb);
      ypitch2_r <= 35'(y1_r) * 35'(geo.pitch);
      xb2_r     <= XB_W'(x1_r) * XB_W'(cfg.bytes_per_element);
      ygob2_r   <= ygob_prod[POS_W-1:0];
    end
    if (rdy3 && v2_r) begin
      lin3_r <= LIN_W'(lsum) * LIN_W'(cfg.bytes_per_element);
      pos3_r <= cfg.tile_mode ? pos_blk : pos_pitch;
    end
    if (rdy4 && v3_r) begin
      out_r.linear_offset <= lin3_r[OFS_W-1:0];
      out_r.tiled_offset  <= pos3_r[OFS_W-1:0];
      out_r.fits_surface  <= ((39'(pos3_r) + 39'(cfg.bytes_per_element)) <= 39'(geo.surf));
    end
  end

  assign out_valid = v4_r;
  assign out_data  = out_r;

endmodule

// ----- rtl/block_linear_swizzle_address.sv -----
// Top level of the block-linear / pitch swizzle address generator.
//
// Input channel in_valid/in_stall/in_data carries one texel-block coordinate
// per request; output channel out_valid/out_stall/out_data returns the linear
// byte offset, the tiled (pitch or block-linear GOB) byte offset and a flag
// telling whether the tiled element ends within the aligned surface size.
// Throughput is one request per cycle while in_stall is low; each result
// passes through four pipeline registers, the last one driving the output.
// When the receiver stalls, the result holds and earlier stages keep
// filling until every stage is occupied, then in_stall rises.
// The configuration port writes one register per cycle on cfg_we. After reset
// and after every configuration write, a geometry sequencer recomputes block
// counts, pitch, GOB stride and surface size, using the 16-step serial divider
// for the block-count round-up. in_stall stays high meanwhile.
// Reset loads the default surface: 1x1 pixels, 4 bytes per element, pitch
// mode, 16 GOBs per block, 512-byte alignment.
module block_linear_swizzle_address #(
  parameter int MAX_DIM_BITS = 14
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  bls_pkg::in_t                        in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output bls_pkg::out_t                       out_data,
  input  logic                                cfg_we,
  input  logic [bls_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [bls_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
  import bls_pkg::*;

  cfg_t cfg_r;
  geo_t geo;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.width_px          <= 15'd1;
      cfg_r.height_px         <= 15'd1;
      cfg_r.block_width       <= 5'd1;
      cfg_r.block_height_px   <= 5'd1;
      cfg_r.bytes_per_element <= 5'd4;
      cfg_r.tile_mode         <= 1'b0;
      cfg_r.gob_height_log2   <= 3'd4;
      cfg_r.alignment         <= 17'd512;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_WIDTH_PX:          cfg_r.width_px          <= cfg_wdata[14:0];
        CFG_HEIGHT_PX:         cfg_r.height_px         <= cfg_wdata[14:0];
        CFG_BLOCK_WIDTH:       cfg_r.block_width       <= cfg_wdata[4:0];
        CFG_BLOCK_HEIGHT_PX:   cfg_r.block_height_px   <= cfg_wdata[4:0];
        CFG_BYTES_PER_ELEMENT: cfg_r.bytes_per_element <= cfg_wdata[4:0];
        CFG_TILE_MODE:         cfg_r.tile_mode         <= cfg_wdata[0];
        CFG_GOB_HEIGHT_LOG2:   cfg_r.gob_height_log2   <= cfg_wdata[2:0];
        CFG_ALIGNMENT:         cfg_r.alignment         <= cfg_wdata;
        default: ;
      endcase
    end
  end

  bls_geom u_geom (
    .clk     (clk),
    .rst_n   (rst_n),
    .restart (cfg_we),
    .cfg     (cfg_r),
    .geo     (geo)
  );

  bls_addr #(
    .MAX_DIM_BITS (MAX_DIM_BITS)
  ) u_addr (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .geo       (geo),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ----- dv/tb_block_linear_swizzle_address.sv -----
// Self-checking testbench for the pitch / block-linear swizzle address generator.
module tb_block_linear_swizzle_address;
  timeunit 1ns;
  timeprecision 1ps;

  import bls_pkg::*;

  localparam longint unsigned GOB_BYTES     = 512;
  localparam longint unsigned GOB_ROW_BYTES = 64;
  localparam longint unsigned GOB_ROWS      = 8;
  localparam longint unsigned GOB_HALF      = 256;
  localparam longint unsigned SECTOR_W      = 32;
  localparam longint unsigned SECTOR_SPAN   = 16;
  localparam longint unsigned PITCH_ALIGN_M = 31;
  localparam int STUCK_LIMIT  = 4000;
  localparam int MAX_REPORTS  = 50;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  in_t                  in_data;
  logic                 out_valid;
  logic                 out_stall;
  out_t                 out_data;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  cfg_t surface;
  out_t expected_offsets[$];
  out_t oldest;
  int   error_count;
  int   stuck_cycles;
  int   sender_idle_pct;
  int   recv_stall_pct;

  block_linear_swizzle_address dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic longint unsigned ceil_div(input longint unsigned a,
                                               input longint unsigned b);
    if (b == 0) b = 1;
    return (a + b - 1) / b;
  endfunction

  // Round up by OR-ing in the mask; zero stays zero.
  function automatic longint unsigned round_up_to(input longint unsigned a,
                                                  input longint unsigned m);
    if (a == 0) return 0;
    return ((a - 1) | m) + 1;
  endfunction

  function automatic out_t predict_offsets(input in_t req);
    longint unsigned x, y, bpp, wb, hb, amask, lin, pos, surf, pitch;
    longint unsigned g, bh, rows, gobs_wide, xb, gob;
    out_t pred;
    x     = req.block_x;
    y     = req.block_y;
    bpp   = surface.bytes_per_element;
    wb    = ceil_div(surface.width_px, surface.block_width);
    hb    = ceil_div(surface.height_px, surface.block_height_px);
    amask = (surface.alignment == 0) ? 0 : surface.alignment - 1;
    lin   = (y * wb + x) * bpp;
    if (surface.tile_mode == 1'b0) begin
      pitch = round_up_to(wb * bpp, PITCH_ALIGN_M);
      surf  = round_up_to(pitch * hb, amask);
      pos   = y * pitch + x * bpp;
    end else begin
      g         = (surface.gob_height_log2 > GOB_MAX_LOG2) ? GOB_MAX_LOG2
                                                           : surface.gob_height_log2;
      bh        = 64'd1 << g;
      rows      = GOB_ROWS * bh;
      pitch     = round_up_to(wb * bpp, GOB_ROW_BYTES - 1);
      gobs_wide = ceil_div(wb * bpp, GOB_ROW_BYTES);
      xb        = x * bpp;
      surf      = round_up_to(pitch * round_up_to(hb, rows - 1), amask);
      gob = (y >> (g + 3)) * GOB_BYTES * bh * gobs_wide
          + (xb / GOB_ROW_BYTES) * GOB_BYTES * bh
          + ((y & (rows - 1)) >> 3) * GOB_BYTES;
      // intra-GOB interleave: half, row pair, sector, row parity, byte
      pos = gob + ((xb % GOB_ROW_BYTES) / SECTOR_W) * GOB_HALF
          + ((y % GOB_ROWS) / 2) * GOB_ROW_BYTES
          + ((xb % SECTOR_W) / SECTOR_SPAN) * SECTOR_W
          + (y % 2) * SECTOR_SPAN + (xb % SECTOR_SPAN);
    end
    pred.linear_offset = lin[OFS_W-1:0];
    pred.tiled_offset  = pos[OFS_W-1:0];
    pred.fits_surface  = (pos + bpp <= surf);
    return pred;
  endfunction

  task automatic report_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want);
    if (error_count < MAX_REPORTS)
      $display("[%0t] mismatch %s: got 0x%0h expected 0x%0h", $time, what, got, want);
    error_count++;
  endtask

  // Predict on each accepted request, check each accepted result in order.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) expected_offsets.push_back(predict_offsets(in_data));
      if (out_valid && !out_stall) begin
        if (expected_offsets.size() == 0) begin
          report_mismatch("result with no request pending", out_data.tiled_offset, 0);
        end else begin
          oldest = expected_offsets.pop_front();
          if (out_data.linear_offset !== oldest.linear_offset)
            report_mismatch("linear_offset", out_data.linear_offset, oldest.linear_offset);
          if (out_data.tiled_offset !== oldest.tiled_offset)
            report_mismatch("tiled_offset", out_data.tiled_offset, oldest.tiled_offset);
          if (out_data.fits_surface !== oldest.fits_surface)
            report_mismatch("fits_surface", out_data.fits_surface, oldest.fits_surface);
        end
      end
    end
  end

  always @(negedge clk) begin
    out_stall = ($urandom_range(99) < recv_stall_pct);
  end

  initial begin : watchdog
    stuck_cycles = 0;
    while (stuck_cycles < STUCK_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) stuck_cycles = 0;
      else stuck_cycles++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  task automatic send_coord(input int unsigned bx, input int unsigned by);
    @(negedge clk);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data  = '{block_x: COORD_W'(bx), block_y: COORD_W'(by)};
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_valid = 1'b0;
    while (expected_offsets.size() != 0) @(posedge clk);
  endtask

  // Write one register once the pipeline is empty; junk above the field is dropped.
  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] data);
    drain_results();
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = data;
    @(posedge clk);
    case (idx)
      CFG_WIDTH_PX:          surface.width_px          = data[14:0];
      CFG_HEIGHT_PX:         surface.height_px         = data[14:0];
      CFG_BLOCK_WIDTH:       surface.block_width       = data[4:0];
      CFG_BLOCK_HEIGHT_PX:   surface.block_height_px   = data[4:0];
      CFG_BYTES_PER_ELEMENT: surface.bytes_per_element = data[BPP_W-1:0];
      CFG_TILE_MODE:         surface.tile_mode         = data[0];
      CFG_GOB_HEIGHT_LOG2:   surface.gob_height_log2   = data[2:0];
      CFG_ALIGNMENT:         surface.alignment         = data[16:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic set_surface(input cfg_t s);
    logic [CFG_DATA_W-1:0] junk;
    junk = CFG_DATA_W'($urandom);
    write_reg(CFG_WIDTH_PX,          {junk[16:15], s.width_px});
    write_reg(CFG_HEIGHT_PX,         {junk[14:13], s.height_px});
    write_reg(CFG_BLOCK_WIDTH,       {junk[16:5], s.block_width});
    write_reg(CFG_BLOCK_HEIGHT_PX,   {junk[11:0], s.block_height_px});
    write_reg(CFG_BYTES_PER_ELEMENT, {junk[15:4], s.bytes_per_element});
    write_reg(CFG_TILE_MODE,         {junk[16:1], s.tile_mode});
    write_reg(CFG_GOB_HEIGHT_LOG2,   {junk[13:0], s.gob_height_log2});
    write_reg(CFG_ALIGNMENT,         s.alignment);
  endtask

  function automatic logic [14:0] random_dim();
    case ($urandom_range(5))
      0:       return 15'd1;
      1:       return 15'd16384;
      2:       return 15'($urandom_range(16385, 32767));
      default: return 15'($urandom_range(1, 2048));
    endcase
  endfunction

  function automatic cfg_t random_surface();
    cfg_t s;
    s.width_px          = random_dim();
    s.height_px         = random_dim();
    s.block_width       = ($urandom_range(9) == 0) ? 5'($urandom) : 5'($urandom_range(1, 16));
    s.block_height_px   = ($urandom_range(9) == 0) ? 5'($urandom) : 5'($urandom_range(1, 16));
    s.bytes_per_element = ($urandom_range(3) == 0) ? 5'($urandom)
                                                   : 5'(1 << $urandom_range(0, 4));
    s.tile_mode         = 1'($urandom_range(1));
    s.gob_height_log2   = 3'($urandom_range(7));
    s.alignment         = ($urandom_range(4) == 0) ? 17'($urandom)
                                                   : 17'(1 << $urandom_range(0, 16));
    return s;
  endfunction

  // Mostly inside the surface, the rest anywhere in the coordinate range.
  function automatic int unsigned pick_coord(input longint unsigned extent);
    if (extent != 0 && $urandom_range(9) < 7)
      return $urandom_range(0, (extent > 16384) ? 16383 : int'(extent - 1));
    return $urandom_range(0, 16383);
  endfunction

  task automatic test_reset_surface();
    send_coord(0, 0);
    send_coord(0, 1);
    send_coord(16383, 16383);
  endtask

  task automatic test_pitch_extremes();
    // width, height, block w/h, bytes, mode, gob log2, alignment
    set_surface('{16384, 16384, 1, 1, 16, 0, 0, 65536});
    send_coord(0, 0);
    send_coord(16383, 0);
    send_coord(0, 16383);
    send_coord(16383, 16383);
    send_coord(14'h2AAA, 14'h1555);
  endtask

  task automatic test_block_linear_gobs();
    set_surface('{1000, 600, 4, 4, 16, 1, 0, 512});
    for (int g = 0; g < 8; g++) begin
      write_reg(CFG_GOB_HEIGHT_LOG2, CFG_DATA_W'(g));
      send_coord($urandom_range(0, 249), $urandom_range(0, 149));
    end
  endtask

  task automatic test_special_cases();
    // zero block size counts as one; last element and one past the row
    set_surface('{100, 50, 0, 0, 4, 0, 4, 256});
    send_coord(99, 49);
    send_coord(100, 0);
    // zero alignment: no rounding
    set_surface('{300, 70, 1, 1, 8, 1, 2, 0});
    send_coord(299, 69);
    // alignment that is not a power of two
    set_surface('{123, 45, 1, 1, 3, 0, 1, 3000});
    send_coord(122, 44);
    // nothing to round: zero width, then zero bytes per element
    set_surface('{0, 10, 1, 1, 4, 1, 3, 64});
    send_coord(0, 0);
    set_surface('{64, 64, 1, 1, 0, 0, 4, 64});
    send_coord(5, 5);
    // surface size wider than the output offset field
    set_surface('{32767, 32767, 1, 1, 31, 1, 5, 65536});
    send_coord(16383, 16383);
  endtask

  task automatic test_random_surfaces();
    cfg_t s;
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin sender_idle_pct = 51; recv_stall_pct = 0;  end
        2:       begin sender_idle_pct = 0;  recv_stall_pct = 51; end
        default: begin sender_idle_pct = 19; recv_stall_pct = 19; end
      endcase
      for (int k = 0; k < 5; k++) begin
        s = random_surface();
        set_surface(s);
        for (int n = 0; n < 30; n++)
          send_coord(pick_coord(ceil_div(s.width_px, s.block_width)),
                     pick_coord(ceil_div(s.height_px, s.block_height_px)));
      end
    end
  endtask

  initial begin
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_data         = '0;
    out_stall       = 1'b0;
    cfg_we          = 1'b0;
    cfg_index       = '0;
    cfg_wdata       = '0;
    sender_idle_pct = 0;
    recv_stall_pct  = 0;
    error_count     = 0;
    surface         = '{1, 1, 1, 1, 4, 0, 4, 512};
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_reset_surface();
    test_pitch_extremes();
    test_block_linear_gobs();
    test_special_cases();
    test_random_surfaces();

    drain_results();
    repeat (8) @(posedge clk);
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
